// ===== rtl/core/rgbtp_pkg.sv =====
// ============================================================================
// RGB triplet text parser package
// Shared types, character constants and level and limit constants for the LED text command parser.
// ============================================================================
package rgbtp_pkg;

    typedef enum logic [2:0] {
        PH_SEEK_OPEN = 3'd0,
        PH_SEEK_LED  = 3'd1,
        PH_RED       = 3'd2,
        PH_GREEN     = 3'd3,
        PH_BLUE      = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_LED   = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_write;
    } t_in_beat;

    typedef struct packed {
        t_kind      result_kind;
        logic [7:0] led_index;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [2:0] bad_components;
        logic [8:0] leds_parsed;
        logic       last_result;
    } t_out_beat;

    localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;
    localparam logic [7:0] CH_OPEN_BRACE    = 8'h7B;
    localparam logic [7:0] CH_CLOSE_BRACE   = 8'h7D;
    localparam logic [7:0] CH_COMMA         = 8'h2C;
    localparam logic [7:0] CH_DIGIT_0       = 8'h30;
    localparam logic [7:0] CH_DIGIT_9       = 8'h39;
    localparam logic [7:0] LEVEL_SAT        = 8'hFF;
    localparam logic [8:0] LED_LIMIT_RESET  = 9'd256;

endpackage

// ===== rtl/core/rgb_triplet_text_parser_core.sv =====
// ============================================================================
// RGB triplet text parser core
// Parses text of the form [{r,g,b}{r,g,b}...] one byte per beat and emits
// LED records, a frame done result or a frame error result.
// ============================================================================
//  channel | direction | signals                              | beat
//  --------+-----------+--------------------------------------+----------------
//  in      | sink      | i_in_valid, o_in_ready, i_in         | one text byte
//  out     | source    | o_out_valid, i_out_ready, o_out      | one result
//  cfg     | sink      | i_cfg_valid, o_cfg_ready, i_cfg_data | LED limit write
//
//  A byte is registered on input and parsed when the two-entry result queue
//  has room for its results, which are written into it; one byte per cycle is
//  sustained while each byte gives at most one result and the output drains.
//  A byte giving two results waits until both queue entries are free.
//  Synchronous active-low reset returns the parser to the search for '['.
//  The configuration port is always ready.
// ============================================================================
module rgb_triplet_text_parser_core #(
    parameter int unsigned MAX_LEDS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rgbtp_pkg::t_in_beat   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rgbtp_pkg::t_out_beat  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [8:0]            i_cfg_data
);

    localparam logic [12:0] MAX_LEDS_C = 13'(MAX_LEDS);

    logic                 r_in_v;
    rgbtp_pkg::t_in_beat  r_in;
    rgbtp_pkg::t_out_beat r_q [2];
    rgbtp_pkg::t_out_beat n_q [2];
    logic [1:0]           r_cnt;
    logic [1:0]           n_cnt;
    logic [8:0]           r_limit;

    rgbtp_pkg::t_phase    r_phase;
    rgbtp_pkg::t_phase    n_phase;
    logic [7:0]           r_acc;
    logic [7:0]           n_acc;
    logic                 r_seen;
    logic                 n_seen;
    logic [2:0]           r_bad;
    logic [2:0]           n_bad;
    logic [7:0]           r_red;
    logic [7:0]           n_red;
    logic [7:0]           r_green;
    logic [7:0]           n_green;
    logic [8:0]           r_led_total;
    logic [8:0]           n_led_total;

    logic                 pop;
    logic [1:0]           cnt_after;
    logic                 fire;
    logic                 accept;
    logic [8:0]           limit_eff;
    logic [8:0]           cnt_inc;
    logic                 is_digit;
    logic [11:0]          acc_next;
    logic [7:0]           blue_val;
    logic [2:0]           bad_blue;
    logic                 frame_over;
    logic [1:0]           nres;
    rgbtp_pkg::t_out_beat res0;
    rgbtp_pkg::t_out_beat res1;
    rgbtp_pkg::t_out_beat err_res;
    rgbtp_pkg::t_out_beat shift0;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_q[0];

    assign pop        = o_out_valid && i_out_ready;
    assign cnt_after  = r_cnt - {1'b0, pop};
    assign fire       = r_in_v && ((3'(cnt_after) + 3'(nres)) <= 3'd2);
    assign o_in_ready = !r_in_v || fire;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        limit_eff = (r_limit == 9'd0) ? 9'd1 : r_limit;
        if (13'(limit_eff) > MAX_LEDS_C) begin
            limit_eff = MAX_LEDS_C[8:0];
        end
    end

    assign cnt_inc  = r_led_total + 9'd1;
    assign is_digit = (r_in.text_byte inside {[rgbtp_pkg::CH_DIGIT_0:rgbtp_pkg::CH_DIGIT_9]});
    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + 12'(r_in.text_byte - rgbtp_pkg::CH_DIGIT_0);
    assign bad_blue = r_bad | {!r_seen, 2'b00};
    assign blue_val = bad_blue[2] ? rgbtp_pkg::LEVEL_SAT : r_acc;

    // Result generation.
    always_comb begin
        res0       = '0;
        res1       = '0;
        err_res    = '0;
        nres       = 2'd0;
        frame_over = 1'b0;
        err_res.result_kind = rgbtp_pkg::KIND_ERROR;
        err_res.leds_parsed = r_led_total;
        case (r_phase)
            rgbtp_pkg::PH_SEEK_LED: begin
                if (r_in.text_byte == rgbtp_pkg::CH_CLOSE_BRACKET) begin
                    res0.result_kind = rgbtp_pkg::KIND_DONE;
                    res0.leds_parsed = r_led_total;
                    nres             = 2'd1;
                    frame_over       = 1'b1;
                end
            end
            rgbtp_pkg::PH_BLUE: begin
                if (r_in.text_byte == rgbtp_pkg::CH_CLOSE_BRACE) begin
                    res0.result_kind    = rgbtp_pkg::KIND_LED;
                    res0.led_index      = r_led_total[7:0];
                    res0.red_level      = r_red;
                    res0.green_level    = r_green;
                    res0.blue_level     = blue_val;
                    res0.bad_components = bad_blue;
                    nres                = 2'd1;
                    err_res.leds_parsed = cnt_inc;
                    if (cnt_inc >= limit_eff) begin
                        res1.result_kind = rgbtp_pkg::KIND_DONE;
                        res1.leds_parsed = cnt_inc;
                        nres             = 2'd2;
                        frame_over       = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!frame_over && r_in.end_of_write) begin
            if (nres == 2'd0) begin
                res0 = err_res;
            end else begin
                res1 = err_res;
            end
            nres = nres + 2'd1;
        end
        if (nres == 2'd1) begin
            res0.last_result = 1'b1;
        end else if (nres == 2'd2) begin
            res1.last_result = 1'b1;
        end
    end

    // Parser state update.
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_seen      = r_seen;
        n_bad       = r_bad;
        n_red       = r_red;
        n_green     = r_green;
        n_led_total = r_led_total;
        case (r_phase)
            rgbtp_pkg::PH_SEEK_OPEN: begin
                if (r_in.text_byte == rgbtp_pkg::CH_OPEN_BRACKET) begin
                    n_phase = rgbtp_pkg::PH_SEEK_LED;
                end
            end
            rgbtp_pkg::PH_SEEK_LED: begin
                if (r_in.text_byte == rgbtp_pkg::CH_OPEN_BRACE) begin
                    n_phase = rgbtp_pkg::PH_RED;
                    n_bad   = 3'b000;
                    n_acc   = 8'd0;
                    n_seen  = 1'b0;
                end
            end
            rgbtp_pkg::PH_RED, rgbtp_pkg::PH_GREEN, rgbtp_pkg::PH_BLUE: begin
                if ((r_phase != rgbtp_pkg::PH_BLUE) &&
                    (r_in.text_byte == rgbtp_pkg::CH_COMMA)) begin
                    if (r_phase == rgbtp_pkg::PH_RED) begin
                        n_bad[0] = r_bad[0] | !r_seen;
                        n_red    = n_bad[0] ? rgbtp_pkg::LEVEL_SAT : r_acc;
                        n_phase  = rgbtp_pkg::PH_GREEN;
                    end else begin
                        n_bad[1] = r_bad[1] | !r_seen;
                        n_green  = n_bad[1] ? rgbtp_pkg::LEVEL_SAT : r_acc;
                        n_phase  = rgbtp_pkg::PH_BLUE;
                    end
                    n_acc  = 8'd0;
                    n_seen = 1'b0;
                end else if ((r_phase == rgbtp_pkg::PH_BLUE) &&
                             (r_in.text_byte == rgbtp_pkg::CH_CLOSE_BRACE)) begin
                    n_bad       = bad_blue;
                    n_led_total = cnt_inc;
                    n_acc       = 8'd0;
                    n_seen      = 1'b0;
                    n_phase     = rgbtp_pkg::PH_SEEK_LED;
                end else if (is_digit) begin
                    n_seen = 1'b1;
                    if (acc_next > 12'd255) begin
                        n_acc = rgbtp_pkg::LEVEL_SAT;
                        n_bad = r_bad | (3'b001 << (r_phase - rgbtp_pkg::PH_RED));
                    end else begin
                        n_acc = acc_next[7:0];
                    end
                end else begin
                    n_bad = r_bad | (3'b001 << (r_phase - rgbtp_pkg::PH_RED));
                end
            end
            default: begin
                n_phase     = rgbtp_pkg::PH_SEEK_OPEN;
                n_led_total = 9'd0;
                n_acc       = 8'd0;
                n_seen      = 1'b0;
                n_bad       = 3'b000;
            end
        endcase
        if (frame_over || r_in.end_of_write) begin
            n_phase     = rgbtp_pkg::PH_SEEK_OPEN;
            n_led_total = 9'd0;
            n_acc       = 8'd0;
            n_seen      = 1'b0;
            n_bad       = 3'b000;
        end
    end

    // Result queue: entry 0 is the head.
    always_comb begin
        shift0 = pop ? r_q[1] : r_q[0];
        n_q[0] = shift0;
        n_q[1] = r_q[1];
        n_cnt  = cnt_after;
        if (fire) begin
            n_cnt = cnt_after + nres;
            if (cnt_after == 2'd0) begin
                n_q[0] = res0;
                n_q[1] = res1;
            end else if (cnt_after == 2'd1) begin
                n_q[1] = res0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v      <= 1'b0;
            r_cnt       <= 2'd0;
            r_limit     <= rgbtp_pkg::LED_LIMIT_RESET;
            r_phase     <= rgbtp_pkg::PH_SEEK_OPEN;
            r_acc       <= 8'd0;
            r_seen      <= 1'b0;
            r_bad       <= 3'b000;
            r_red       <= 8'd0;
            r_green     <= 8'd0;
            r_led_total <= 9'd0;
        end else begin
            if (accept) begin
                r_in_v <= 1'b1;
            end else if (fire) begin
                r_in_v <= 1'b0;
            end
            r_cnt <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (fire) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_seen      <= n_seen;
                r_bad       <= n_bad;
                r_red       <= n_red;
                r_green     <= n_green;
                r_led_total <= n_led_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("Result queue holds more than two entries.");

    a_final_kind_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.result_kind != rgbtp_pkg::KIND_LED)) |-> o_out.last_result)
        else $error("A done or error result is not marked as last.");

    a_seek_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rgbtp_pkg::PH_SEEK_OPEN) |-> ((r_led_total == 9'd0) && (r_bad == 3'b000)))
        else $error("Frame state is not cleared while seeking the opening bracket.");

    a_fire_needs_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> r_in_v)
        else $error("Parser advanced without a registered byte.");

endmodule
